// ===== rtl/core/sttr_pkg.sv =====
// ----------------------------------------------------------------------------
// sttr_pkg
// Shared types, codes and character helpers for the serial time telegram
// receiver.
// ----------------------------------------------------------------------------
package sttr_pkg;

	localparam int COUNTER_WIDTH_DEF = 20;
	localparam int CFG_CNT_W         = 20;
	localparam int MAX_LEN_W         = 6;
	localparam int LEN_W             = MAX_LEN_W + 1;
	localparam int HEAD_DEPTH        = 7;
	localparam int HEAD_IW           = $clog2(HEAD_DEPTH);
	localparam int QDEPTH            = 2;
	localparam int CFG_IDX_W         = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_CLEAR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALE        = 2'd2;

	localparam logic [MAX_LEN_W-1:0] MAX_LINE_LEN_RST = 6'd32;
	localparam logic [CFG_CNT_W-1:0] IDLE_CLEAR_RST   = 20'd5000;
	localparam logic [CFG_CNT_W-1:0] STALE_RST        = 20'd60000;

	// result codes
	localparam logic [3:0] EV_NONE     = 4'd0;
	localparam logic [3:0] EV_DATE_OK  = 4'd1;
	localparam logic [3:0] EV_TIME_OK  = 4'd2;
	localparam logic [3:0] EV_DATE_BAD = 4'd3;
	localparam logic [3:0] EV_TIME_BAD = 4'd4;
	localparam logic [3:0] EV_BAD_LEN  = 4'd5;
	localparam logic [3:0] EV_CLASS    = 4'd6;
	localparam logic [3:0] EV_OVERFLOW = 4'd7;
	localparam logic [3:0] EV_STALE    = 4'd8;

	// operation kinds passed from front to back
	localparam logic [1:0] OP_CHAR = 2'd0;
	localparam logic [1:0] OP_EOL  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic CMD_BYTE = 1'b0;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  event_res;
		logic [47:0] date_chars;
		logic [47:0] time_chars;
		logic        date_present;
		logic        time_valid;
	} out_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
	} op_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
			(c == 8'h0C) || (c == 8'h0D);
	endfunction

	// two-character field read the way atol reads it: -9 .. 99
	function automatic logic signed [7:0] read_pair(input logic [7:0] a, input logic [7:0] b);
		logic signed [7:0] r;
		logic [7:0]        da;
		logic [7:0]        db;
		r  = 8'sd0;
		da = {4'b0, a[3:0]};
		db = {4'b0, b[3:0]};
		if (is_digit(a)) begin
			if (is_digit(b)) begin
				r = $signed(8'(da * 8'd10 + db));
			end else begin
				r = $signed(da);
			end
		end else if ((a == 8'h2B) || (a == 8'h2D)) begin
			if (is_digit(b)) begin
				r = (a == 8'h2D) ? -$signed(db) : $signed(db);
			end
		end else if (is_blank(a) && is_digit(b)) begin
			r = $signed(db);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/sttr_front.sv =====
// ----------------------------------------------------------------------------
// sttr_front
// Input side: accepts words and sorts them into character, end of line or
// tick operations for the queue.
// ----------------------------------------------------------------------------
module sttr_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  sttr_pkg::in_item_t in_data,
	input  logic               q_full,
	output logic               push,
	output sttr_pkg::op_t      push_op
);

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_op.ch = in_data.rx_byte;
		if (in_data.command != sttr_pkg::CMD_BYTE) begin
			push_op.kind = sttr_pkg::OP_TICK;
		end else if ((in_data.rx_byte == 8'h0A) || (in_data.rx_byte == 8'h0D)) begin
			push_op.kind = sttr_pkg::OP_EOL;
		end else begin
			push_op.kind = sttr_pkg::OP_CHAR;
		end
	end

endmodule

// ===== rtl/core/sttr_queue.sv =====
// ----------------------------------------------------------------------------
// sttr_queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module sttr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sttr_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output sttr_pkg::op_t q_op
);

	localparam int QD  = sttr_pkg::QDEPTH;
	localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	sttr_pkg::op_t    mem_q [QD];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	assign full    = (count_q == QCW'(QD));
	assign q_valid = (count_q != '0);
	assign q_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/sttr_back.sv =====
// ----------------------------------------------------------------------------
// sttr_back
// Execution side: line assembly, telegram checks, tick aging and the
// output register.
// ----------------------------------------------------------------------------
module sttr_back #(
	parameter int COUNTER_WIDTH = sttr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  sttr_pkg::op_t                     q_op,
	output logic                              pop,
	input  logic [sttr_pkg::MAX_LEN_W-1:0]    max_line_len,
	input  logic [sttr_pkg::CFG_CNT_W-1:0]    idle_clear_ticks,
	input  logic [sttr_pkg::CFG_CNT_W-1:0]    stale_ticks,
	output logic                              out_valid,
	input  logic                              out_ready,
	output sttr_pkg::out_item_t               out_data
);

	localparam int CW    = COUNTER_WIDTH;
	localparam int CMPW  = (CW > sttr_pkg::CFG_CNT_W) ? CW : sttr_pkg::CFG_CNT_W;
	localparam int LW    = sttr_pkg::LEN_W;
	localparam int HD    = sttr_pkg::HEAD_DEPTH;

	logic [LW-1:0]  len_q;
	logic [7:0]     head_q [HD];
	logic [CW-1:0]  idle_q;
	logic [CW-1:0]  age_q;
	logic [47:0]    date_q;
	logic [47:0]    time_q;
	logic           seen_q;
	logic           vflag_q;
	logic           out_valid_q;
	sttr_pkg::out_item_t out_data_q;

	logic [LW-1:0]  n_len;
	logic [LW-1:0]  len_inc;
	logic [CW-1:0]  n_idle;
	logic [CW-1:0]  n_age;
	logic [47:0]    n_date;
	logic [47:0]    n_time;
	logic           n_seen;
	logic           n_vflag;
	logic [3:0]     ev;
	logic           head_we;

	logic signed [7:0] f0;
	logic signed [7:0] f1;
	logic signed [7:0] f2;
	logic              cls_upper;
	logic              cls_lower;
	logic              date_ok;
	logic              time_ok;
	logic [47:0]       packed_six;

	assign pop       = q_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// telegram decode from the stored head of the line
	always_comb begin
		f0         = sttr_pkg::read_pair(head_q[0], head_q[1]);
		f1         = sttr_pkg::read_pair(head_q[2], head_q[3]);
		f2         = sttr_pkg::read_pair(head_q[4], head_q[5]);
		cls_upper  = (head_q[6] >= 8'h41) && (head_q[6] <= 8'h5A);
		cls_lower  = (head_q[6] >= 8'h61) && (head_q[6] <= 8'h7A);
		date_ok    = (f0 >= 8'sd1) && (f0 <= 8'sd31) && (f1 >= 8'sd1) && (f1 <= 8'sd12) &&
			(f2 >= 8'sd20) && (f2 <= 8'sd99);
		time_ok    = (f0 <= 8'sd23) && (f1 <= 8'sd59) && (f2 <= 8'sd59);
		packed_six = {head_q[0], head_q[1], head_q[2], head_q[3], head_q[4], head_q[5]};
	end

	always_comb begin
		n_len   = len_q;
		n_idle  = idle_q;
		n_age   = age_q;
		n_date  = date_q;
		n_time  = time_q;
		n_seen  = seen_q;
		n_vflag = vflag_q;
		ev      = sttr_pkg::EV_NONE;
		head_we = 1'b0;
		len_inc = len_q + 1'b1;
		unique case (q_op.kind)
			sttr_pkg::OP_CHAR: begin
				n_idle  = '0;
				head_we = (len_q < LW'(HD));
				if (len_inc > {1'b0, max_line_len}) begin
					// line too long: drop it
					n_len = '0;
					ev    = sttr_pkg::EV_OVERFLOW;
				end else begin
					n_len = len_inc;
				end
			end
			sttr_pkg::OP_EOL: begin
				n_idle = '0;
				if (len_q != '0) begin
					n_len = '0;
					if (len_q != LW'(HD)) begin
						ev = sttr_pkg::EV_BAD_LEN;
					end else if (cls_upper) begin
						if (date_ok) begin
							n_date = packed_six;
							n_seen = 1'b1;
							n_age  = '0;
							ev     = sttr_pkg::EV_DATE_OK;
						end else begin
							ev = sttr_pkg::EV_DATE_BAD;
						end
					end else if (cls_lower) begin
						if (time_ok) begin
							n_time  = packed_six;
							n_vflag = 1'b1;
							n_age   = '0;
							ev      = sttr_pkg::EV_TIME_OK;
						end else begin
							ev = sttr_pkg::EV_TIME_BAD;
						end
					end else begin
						ev = sttr_pkg::EV_CLASS;
					end
				end
			end
			sttr_pkg::OP_TICK: begin
				// saturating counters
				n_idle = (&idle_q) ? idle_q : idle_q + 1'b1;
				n_age  = (&age_q) ? age_q : age_q + 1'b1;
				if ((len_q != '0) && (CMPW'(n_idle) > CMPW'(idle_clear_ticks))) begin
					n_len = '0;
				end
				if (vflag_q && (CMPW'(n_age) > CMPW'(stale_ticks))) begin
					n_vflag = 1'b0;
					ev      = sttr_pkg::EV_STALE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && head_we) begin
			head_q[len_q[sttr_pkg::HEAD_IW-1:0]] <= q_op.ch;
		end
		if (pop) begin
			out_data_q.event_res    <= ev;
			out_data_q.date_chars   <= n_date;
			out_data_q.time_chars   <= n_time;
			out_data_q.date_present <= n_seen;
			out_data_q.time_valid   <= n_vflag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			idle_q      <= '0;
			age_q       <= '0;
			date_q      <= '0;
			time_q      <= '0;
			seen_q      <= 1'b0;
			vflag_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				len_q   <= n_len;
				idle_q  <= n_idle;
				age_q   <= n_age;
				date_q  <= n_date;
				time_q  <= n_time;
				seen_q  <= n_seen;
				vflag_q <= n_vflag;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/serial_time_telegram_receiver_top.sv =====
// ----------------------------------------------------------------------------
// serial_time_telegram_receiver_top
// Serial date/time telegram receiver: byte and tick words in, one status
// word out per input word.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+--------------------------------
//  in       | in  | in_valid / in_ready  | in_data  (command, rx_byte)
//  out      | out | out_valid / out_ready| out_data (event, date, time, flags)
//  cfg      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle sustained while out is not stalled; a status word
// reaches out through the queue register and then the output register (the
// back end decodes the queue head and loads the output register). cfg_ready
// is always high. Reset clears the line length and all aging state and loads the
// register defaults; no clearing pass is needed. A stall on out holds the
// back end while the two-entry queue absorbs input.
// ----------------------------------------------------------------------------
module serial_time_telegram_receiver_top #(
	parameter int COUNTER_WIDTH = sttr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  sttr_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output sttr_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sttr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sttr_pkg::CFG_CNT_W-1:0]     cfg_data
);

	logic [sttr_pkg::MAX_LEN_W-1:0] max_line_len_q;
	logic [sttr_pkg::CFG_CNT_W-1:0] idle_clear_q;
	logic [sttr_pkg::CFG_CNT_W-1:0] stale_q;

	logic          push;
	sttr_pkg::op_t push_op;
	logic          q_full;
	logic          pop;
	logic          q_valid;
	sttr_pkg::op_t q_op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_len_q <= sttr_pkg::MAX_LINE_LEN_RST;
			idle_clear_q   <= sttr_pkg::IDLE_CLEAR_RST;
			stale_q        <= sttr_pkg::STALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sttr_pkg::REG_MAX_LINE_LEN: max_line_len_q <= cfg_data[sttr_pkg::MAX_LEN_W-1:0];
				sttr_pkg::REG_IDLE_CLEAR:   idle_clear_q   <= cfg_data;
				sttr_pkg::REG_STALE:        stale_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sttr_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	sttr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_op    (q_op)
	);

	sttr_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_valid          (q_valid),
		.q_op             (q_op),
		.pop              (pop),
		.max_line_len     (max_line_len_q),
		.idle_clear_ticks (idle_clear_q),
		.stale_ticks      (stale_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_data         (out_data)
	);

	// a stale report always comes with the flag down
	a_stale_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res == sttr_pkg::EV_STALE) |-> !out_data.time_valid)
		else $error("stale word with time_valid set");

	a_time_ok_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res == sttr_pkg::EV_TIME_OK) |-> out_data.time_valid)
		else $error("time accepted without time_valid");

	a_date_ok_sets_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res == sttr_pkg::EV_DATE_OK) |-> out_data.date_present)
		else $error("date accepted without date_present");

	// a result is produced only from a queued word
	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_valid))
		else $error("output word without a queued operation");

endmodule

// ===== tb/sv/sttr_status_checker.sv =====
// ----------------------------------------------------------------------------
// sttr_status_checker
// Watches the byte/tick, status and register channels of the serial time
// telegram receiver, keeps its own copy of the line and aging state, and
// compares every status word against the predicted one.
// ----------------------------------------------------------------------------
module sttr_status_checker #(
	parameter int COUNTER_WIDTH = sttr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  sttr_pkg::in_item_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  sttr_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sttr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sttr_pkg::CFG_CNT_W-1:0] cfg_data,
	output int                             errors,
	output int                             outstanding,
	output int                             compared
);
	timeunit 1ns;
	timeprecision 1ps;

	import sttr_pkg::*;

	localparam logic [COUNTER_WIDTH-1:0] TICK_SAT = '1;

	localparam logic [7:0] ASCII_TAB   = 8'h09;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_VT    = 8'h0B;
	localparam logic [7:0] ASCII_FF    = 8'h0C;
	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_NINE  = 8'h39;
	localparam logic [7:0] ASCII_UP_A  = 8'h41;
	localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
	localparam logic [7:0] ASCII_LO_A  = 8'h61;
	localparam logic [7:0] ASCII_LO_Z  = 8'h7A;

	// register copy
	logic [MAX_LEN_W-1:0] max_len_q;
	logic [CFG_CNT_W-1:0] idle_limit_q;
	logic [CFG_CNT_W-1:0] stale_limit_q;

	// line and aging state
	logic [LEN_W-1:0]         line_len;
	logic [7:0]               line_chars [HEAD_DEPTH];
	logic [COUNTER_WIDTH-1:0] idle_ticks;
	logic [COUNTER_WIDTH-1:0] data_age;
	logic [47:0]              date_q;
	logic [47:0]              time_q;
	logic                     date_seen_q;
	logic                     time_ok_q;

	out_item_t status_q [$];
	out_item_t status_want;
	int        mismatch_count;
	int        compared_count;

	function automatic logic is_num(input logic [7:0] c);
		return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
	endfunction

	function automatic int digit_of(input logic [7:0] c);
		return int'(c) - int'(ASCII_ZERO);
	endfunction

	// two characters read like atol: optional blank, optional sign, digits
	function automatic int pair_value(input logic [7:0] a, input logic [7:0] b);
		logic lead_blank;
		lead_blank = (a == ASCII_SPACE) || (a == ASCII_TAB) || (a == ASCII_LF) ||
			(a == ASCII_VT) || (a == ASCII_FF) || (a == ASCII_CR);
		if (is_num(a)) begin
			return is_num(b) ? digit_of(a) * 10 + digit_of(b) : digit_of(a);
		end
		if ((a == ASCII_PLUS) || (a == ASCII_MINUS)) begin
			if (!is_num(b))
				return 0;
			return (a == ASCII_MINUS) ? -digit_of(b) : digit_of(b);
		end
		if (lead_blank && is_num(b))
			return digit_of(b);
		return 0;
	endfunction

	function automatic logic [3:0] close_line();
		int          f0;
		int          f1;
		int          f2;
		logic [7:0]  cls;
		logic [47:0] six;
		if (line_len != LEN_W'(HEAD_DEPTH))
			return EV_BAD_LEN;
		cls = line_chars[6];
		f0  = pair_value(line_chars[0], line_chars[1]);
		f1  = pair_value(line_chars[2], line_chars[3]);
		f2  = pair_value(line_chars[4], line_chars[5]);
		six = {line_chars[0], line_chars[1], line_chars[2],
			line_chars[3], line_chars[4], line_chars[5]};
		if ((cls >= ASCII_UP_A) && (cls <= ASCII_UP_Z)) begin
			if (f0 < 1 || f0 > 31 || f1 < 1 || f1 > 12 || f2 < 20 || f2 > 99)
				return EV_DATE_BAD;
			date_q      = six;
			date_seen_q = 1'b1;
			data_age    = '0;
			return EV_DATE_OK;
		end
		if ((cls >= ASCII_LO_A) && (cls <= ASCII_LO_Z)) begin
			if (f0 > 23 || f1 > 59 || f2 > 59)
				return EV_TIME_BAD;
			time_q    = six;
			time_ok_q = 1'b1;
			data_age  = '0;
			return EV_TIME_OK;
		end
		return EV_CLASS;
	endfunction

	// advance the state by one word and return the status word it yields
	function automatic out_item_t next_status(input in_item_t w);
		out_item_t  r;
		logic [3:0] ev;
		ev = EV_NONE;
		if (w.command == CMD_BYTE) begin
			idle_ticks = '0;
			if ((w.rx_byte == ASCII_LF) || (w.rx_byte == ASCII_CR)) begin
				if (line_len != '0) begin
					ev       = close_line();
					line_len = '0;
				end
			end else begin
				if (line_len < LEN_W'(HEAD_DEPTH))
					line_chars[line_len[HEAD_IW-1:0]] = w.rx_byte;
				line_len++;
				if (line_len > {1'b0, max_len_q}) begin
					line_len = '0;
					ev       = EV_OVERFLOW;
				end
			end
		end else begin
			if (idle_ticks != TICK_SAT)
				idle_ticks++;
			if (data_age != TICK_SAT)
				data_age++;
			if ((line_len != '0) && (idle_ticks > idle_limit_q))
				line_len = '0;
			if (time_ok_q && (data_age > stale_limit_q)) begin
				time_ok_q = 1'b0;
				ev        = EV_STALE;
			end
		end
		r.event_res    = ev;
		r.date_chars   = date_q;
		r.time_chars   = time_q;
		r.date_present = date_seen_q;
		r.time_valid   = time_ok_q;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [47:0] want,
		input logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q      = MAX_LINE_LEN_RST;
			idle_limit_q   = IDLE_CLEAR_RST;
			stale_limit_q  = STALE_RST;
			line_len       = '0;
			idle_ticks     = '0;
			data_age       = '0;
			date_q         = '0;
			time_q         = '0;
			date_seen_q    = 1'b0;
			time_ok_q      = 1'b0;
			mismatch_count = 0;
			compared_count = 0;
			for (int i = 0; i < HEAD_DEPTH; i++)
				line_chars[i] = '0;
			status_q.delete();
			errors      <= 0;
			outstanding <= 0;
			compared    <= 0;
		end else begin
			// compare first: a status word leaving now belongs to an older word
			if (out_valid && out_ready) begin
				if (status_q.size() == 0) begin
					$error("status word 0x%0h arrived with nothing expected", out_data);
					mismatch_count++;
				end else begin
					status_want = status_q.pop_front();
					check_field("event_res", 48'(status_want.event_res),
						48'(out_data.event_res));
					check_field("date_chars", status_want.date_chars, out_data.date_chars);
					check_field("time_chars", status_want.time_chars, out_data.time_chars);
					check_field("date_present", 48'(status_want.date_present),
						48'(out_data.date_present));
					check_field("time_valid", 48'(status_want.time_valid),
						48'(out_data.time_valid));
					compared_count++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MAX_LINE_LEN: max_len_q = cfg_data[MAX_LEN_W-1:0];
					REG_IDLE_CLEAR: idle_limit_q = cfg_data;
					REG_STALE: stale_limit_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				status_q.push_back(next_status(in_data));
			errors      <= mismatch_count;
			outstanding <= status_q.size();
			compared    <= compared_count;
		end
	end

endmodule

// ===== tb/sv/tb_serial_time_telegram_receiver_top.sv =====
// ----------------------------------------------------------------------------
// tb_serial_time_telegram_receiver_top
// Drives byte and tick words into the telegram receiver through bursts and
// gaps while the status side stalls on its own pattern; a side checker
// predicts and compares every status word across several register settings.
// ----------------------------------------------------------------------------
module tb_serial_time_telegram_receiver_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sttr_pkg::*;

	localparam int         CNT_W     = COUNTER_WIDTH_DEF;
	localparam int         RUN_LIMIT = 5_000_000;
	localparam int         LONG_HOLD = 400;
	localparam logic       CMD_TICK  = ~CMD_BYTE;
	localparam logic [19:0] CNT_TOP  = 20'hFFFFF;

	localparam logic [7:0] ASCII_TAB   = 8'h09;
	localparam logic [7:0] ASCII_LF    = 8'h0A;
	localparam logic [7:0] ASCII_VT    = 8'h0B;
	localparam logic [7:0] ASCII_FF    = 8'h0C;
	localparam logic [7:0] ASCII_CR    = 8'h0D;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_UP_A  = 8'h41;
	localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
	localparam logic [7:0] ASCII_LO_A  = 8'h61;
	localparam logic [7:0] ASCII_LO_Z  = 8'h7A;

	typedef enum int {SINK_RANDOM, SINK_ALWAYS, SINK_PERIODIC} sink_mode_e;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_CNT_W-1:0] cfg_data;

	int errors;
	int outstanding;
	int compared;

	int         words_sent;
	int         burst_left;
	int         settings_used;
	int         tick_span;
	int         cur_max_len;
	int         cycle_count;
	int         sink_cycle;
	bit         src_gaps;
	bit         long_hold_req;
	sink_mode_e sink_mode;

	serial_time_telegram_receiver_top #(
		.COUNTER_WIDTH(CNT_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	sttr_status_checker #(
		.COUNTER_WIDTH(CNT_W)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (errors),
		.outstanding(outstanding),
		.compared   (compared)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// status side: random stalls, a fixed pattern, always ready, or one long hold
	initial begin : sink
		int stall_left;
		stall_left = 0;
		sink_cycle = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			sink_cycle++;
			if (long_hold_req) begin
				// hold off long enough for the queue to fill and block input
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (sink_mode == SINK_ALWAYS) begin
				out_ready <= 1'b1;
			end else if (sink_mode == SINK_PERIODIC) begin
				out_ready <= (sink_cycle % 9) < 5;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(5, 0) == 0) begin
				stall_left = $urandom_range(11, 0);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic cmd, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = src_gaps ? $urandom_range(5, 0) : 0;
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= '{command: cmd, rx_byte: b};
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(CMD_BYTE, b);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_word(CMD_TICK, 8'h00);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic end_line();
		send_byte($urandom_range(1, 0) ? ASCII_CR : ASCII_LF);
	endtask

	// drop valid and wait until every status word is back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_CNT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input int max_len, input logic [19:0] idle_lim,
		input logic [19:0] stale_lim);
		settle();
		write_reg(REG_MAX_LINE_LEN, CFG_CNT_W'(max_len));
		write_reg(REG_IDLE_CLEAR, idle_lim);
		write_reg(REG_STALE, stale_lim);
		cur_max_len = max_len;
		settings_used++;
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(255, 0)); while (c == ASCII_CR || c == ASCII_LF);
		return c;
	endfunction

	function automatic logic [15:0] two_digits(input int v);
		return {ASCII_ZERO + 8'(v / 10), ASCII_ZERO + 8'(v % 10)};
	endfunction

	// one two-character field: in range, at its edges, or malformed
	function automatic logic [15:0] field_pair(input int lo, input int hi);
		int         pick;
		int         v;
		logic [7:0] blank;
		pick = $urandom_range(19, 0);
		if (pick < 10) begin
			return two_digits($urandom_range(hi, lo));
		end else if (pick < 14) begin
			case ($urandom_range(3, 0))
				0: v = lo - 1;
				1: v = lo;
				2: v = hi;
				default: v = hi + 1;
			endcase
			if (v < 0) v = 0;
			if (v > 99) v = 99;
			return two_digits(v);
		end else if (pick < 16) begin
			return two_digits($urandom_range(99, 0));
		end else if (pick == 16) begin
			return {$urandom_range(1, 0) ? ASCII_MINUS : ASCII_PLUS,
				ASCII_ZERO + 8'($urandom_range(9, 0))};
		end else if (pick == 17) begin
			case ($urandom_range(3, 0))
				0: blank = ASCII_SPACE;
				1: blank = ASCII_TAB;
				2: blank = ASCII_VT;
				default: blank = ASCII_FF;
			endcase
			return {blank, ASCII_ZERO + 8'($urandom_range(9, 0))};
		end else if (pick == 18) begin
			return {ASCII_ZERO + 8'($urandom_range(9, 0)), text_byte()};
		end
		return {text_byte(), text_byte()};
	endfunction

	task automatic send_telegram();
		logic [7:0]  tele [8];
		logic [15:0] p0;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [7:0]  cls;
		int          pick;
		pick = $urandom_range(19, 0);
		if (pick < 9 || (pick >= 18 && pick[0])) begin
			p0 = field_pair(1, 31);
			p1 = field_pair(1, 12);
			p2 = field_pair(20, 99);
		end else begin
			p0 = field_pair(0, 23);
			p1 = field_pair(0, 59);
			p2 = field_pair(0, 59);
		end
		if (pick < 9) begin
			cls = 8'($urandom_range(ASCII_UP_Z, ASCII_UP_A));
		end else if (pick < 18) begin
			cls = 8'($urandom_range(ASCII_LO_Z, ASCII_LO_A));
		end else begin
			do cls = text_byte();
			while ((cls >= ASCII_UP_A && cls <= ASCII_UP_Z) ||
				(cls >= ASCII_LO_A && cls <= ASCII_LO_Z));
		end
		{tele[0], tele[1]} = p0;
		{tele[2], tele[3]} = p1;
		{tele[4], tele[5]} = p2;
		tele[6] = cls;
		tele[7] = $urandom_range(1, 0) ? ASCII_CR : ASCII_LF;
		for (int k = 0; k < 8; k++) begin
			// now and then let the line age between characters
			if ($urandom_range(15, 0) == 0)
				send_ticks($urandom_range(tick_span, 1));
			send_byte(tele[k]);
		end
	endtask

	task automatic send_random_line();
		int n;
		n = $urandom_range(cur_max_len + 3, 1);
		repeat (n) send_byte(text_byte());
		end_line();
	endtask

	task automatic run_random(input int n);
		int target;
		int pick;
		target = words_sent + n;
		while (words_sent < target) begin
			pick = $urandom_range(19, 0);
			if (pick < 11) send_telegram();
			else if (pick < 14) send_random_line();
			else if (pick < 16) send_byte(8'($urandom_range(255, 0)));
			else if (pick < 19) send_ticks($urandom_range(tick_span, 1));
			else end_line();
		end
	endtask

	initial begin : stimulus
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		words_sent    = 0;
		burst_left    = 0;
		settings_used = 0;
		tick_span     = 4;
		cur_max_len   = 32;
		src_gaps      = 1'b1;
		long_hold_req = 1'b0;
		sink_mode     = SINK_RANDOM;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: empty line, then a date at the low edges
		send_byte(ASCII_CR);
		send_text("010120A");
		send_byte(ASCII_LF);

		// tightest limits: time at the high edges, stale, idle clear
		configure(7, 20'd1, 20'd1);
		send_text("235959z");
		send_byte(ASCII_CR);
		send_ticks(2);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_ticks(2);
		send_byte(ASCII_LF);

		configure(32, 20'd5000, 20'd60000);
		tick_span = 6;
		run_random(320);

		configure(63, 20'd3, 20'd20);
		sink_mode = SINK_PERIODIC;
		tick_span = 8;
		run_random(320);

		configure(7, CNT_TOP, CNT_TOP);
		sink_mode = SINK_RANDOM;
		tick_span = 4;
		run_random(280);

		configure(12, 20'd8, 20'd40);
		long_hold_req = 1'b1;
		tick_span = 12;
		run_random(380);

		// below the legal line length: no telegram can pass the length check
		configure(5, 20'd2, 20'd1);
		sink_mode = SINK_PERIODIC;
		tick_span = 4;
		run_random(180);

		configure(20, 20'd50, 20'd100);
		src_gaps  = 1'b0;
		sink_mode = SINK_ALWAYS;
		tick_span = 60;
		run_random(320);

		// age a time and a partial line under wide limits, then lower the limits
		configure(10, CNT_TOP, CNT_TOP);
		send_text("120000a");
		send_byte(ASCII_CR);
		send_text("12");
		send_ticks(40);
		configure(10, 20'd1, 20'd30);
		send_ticks(1);
		send_text("34567");
		send_byte(ASCII_LF);

		settle();
		repeat (8) @(posedge clk);
		$display("Covered %0d input words under %0d register settings, %0d status words compared.",
			words_sent, settings_used, compared);
		$display("Included a %0d-cycle output hold and a stale drop after lowered limits.",
			LONG_HOLD);
		if (errors == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== serial_time_telegram_receiver_top.f =====
rtl/core/sttr_pkg.sv
rtl/core/sttr_front.sv
rtl/core/sttr_queue.sv
rtl/core/sttr_back.sv
rtl/core/serial_time_telegram_receiver_top.sv
tb/sv/sttr_status_checker.sv
tb/sv/tb_serial_time_telegram_receiver_top.sv
